### hw/rtl/hblw_pkg.sv
// Package for the height blend layer weights block.
// Holds field widths, register codes, reset values and the transaction structs.
// No dependencies.
`default_nettype none

package hblw_pkg;

    localparam int LAYER_COUNT = 4;

    // Quotient width of every division: results lie in 0..32768.
    localparam int Q_W = 16;
    // Width of a splat or ramp sum over all layers.
    localparam int SUM_W = 16 + $clog2(LAYER_COUNT);
    // Adjusted height, signed: height plus a boost of at most 32767.
    localparam int H_W = 18;
    // Ramp numerator h - hmax + te, signed.
    localparam int N_W = 19;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 15;

    localparam logic [CFG_IDX_W-1:0] REG_SHARPNESS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TRANSITION = 2'd1;

    localparam logic [CFG_DATA_W-1:0] SHARPNESS_RESET  = 15'd2048;
    localparam logic [CFG_DATA_W-1:0] TRANSITION_RESET = 15'd819;
    localparam logic [CFG_DATA_W-1:0] MIN_TRANSITION   = 15'd4;

    localparam logic [Q_W:0] ONE_Q15 = 17'd32768;

    typedef struct packed {
        logic signed [15:0] height_0;
        logic signed [15:0] height_1;
        logic signed [15:0] height_2;
        logic signed [15:0] height_3;
        logic signed [15:0] splat_0;
        logic signed [15:0] splat_1;
        logic signed [15:0] splat_2;
        logic signed [15:0] splat_3;
    } pixel_t;

    typedef struct packed {
        logic [15:0] weight_0;
        logic [15:0] weight_1;
        logic [15:0] weight_2;
        logic [15:0] weight_3;
        logic        used_splat;
    } blend_t;

endpackage

`default_nettype wire

### hw/rtl/hblw_div.sv
// Pipelined restoring divider: (num << 15) / den for several lanes sharing a divisor.
// Requires num <= den, so each quotient fits in 0..32768. Depends on hblw_pkg.
`default_nettype none

module hblw_div
    import hblw_pkg::*;
#(
    parameter int DW    = SUM_W,
    parameter int LANES = LAYER_COUNT,
    parameter int SIDE  = 1
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         en,
    input  wire logic                         in_valid,
    input  wire logic [LANES-1:0][DW-1:0]     num,
    input  wire logic [DW-1:0]                den,
    input  wire logic [SIDE-1:0]              side_in,
    output logic                              out_valid,
    output logic [LANES-1:0][Q_W-1:0]         quo,
    output logic [SIDE-1:0]                   side_out
);

    localparam int BPS = 2;
    localparam int NST = Q_W / BPS;

    logic [NST-1:0]              v_reg;
    logic [LANES-1:0][DW:0]      p_reg [NST];
    logic [LANES-1:0][Q_W-1:0]   q_reg [NST];
    logic [DW-1:0]               d_reg [NST];
    logic [SIDE-1:0]             s_reg [NST];

    logic [LANES-1:0][DW:0]      p_src  [NST];
    logic [LANES-1:0][Q_W-1:0]   q_src  [NST];
    logic [DW-1:0]               d_src  [NST];
    logic [SIDE-1:0]             s_src  [NST];
    logic [NST-1:0]              v_src;
    logic [LANES-1:0][DW:0]      p_next [NST];
    logic [LANES-1:0][Q_W-1:0]   q_next [NST];

    for (genvar st = 0; st < NST; st++) begin : g_stage
        if (st == 0) begin : g_first
            for (genvar l = 0; l < LANES; l++) begin : g_lane
                assign p_src[0][l] = {1'b0, num[l]};
            end
            assign q_src[0] = '0;
            assign d_src[0] = den;
            assign s_src[0] = side_in;
            assign v_src[0] = in_valid;
        end else begin : g_rest
            assign p_src[st] = p_reg[st-1];
            assign q_src[st] = q_reg[st-1];
            assign d_src[st] = d_reg[st-1];
            assign s_src[st] = s_reg[st-1];
            assign v_src[st] = v_reg[st-1];
        end

        // The very first step compares the numerator itself, which yields
        // the integer bit of the Q1.15 quotient; later steps shift first.
        always_comb
        begin
            logic [DW:0]    p;
            logic [Q_W-1:0] q;
            for (int l = 0; l < LANES; l++)
            begin
                p = p_src[st][l];
                q = q_src[st][l];
                for (int b = 0; b < BPS; b++)
                begin
                    if (st * BPS + b != 0)
                    begin
                        p = {p[DW-1:0], 1'b0};
                    end
                    if (p >= {1'b0, d_src[st]})
                    begin
                        p = p - {1'b0, d_src[st]};
                        q = {q[Q_W-2:0], 1'b1};
                    end
                    else
                    begin
                        q = {q[Q_W-2:0], 1'b0};
                    end
                end
                p_next[st][l] = p;
                q_next[st][l] = q;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[st] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[st] <= v_src[st];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                p_reg[st] <= p_next[st];
                q_reg[st] <= q_next[st];
                d_reg[st] <= d_src[st];
                s_reg[st] <= s_src[st];
            end
        end
    end

    assign out_valid = v_reg[NST-1];
    assign quo       = q_reg[NST-1];
    assign side_out  = s_reg[NST-1];

endmodule

`default_nettype wire

### hw/rtl/height_blend_layer_weights.sv
// Top level of the height blend layer weights block.
// Depends on hblw_pkg and hblw_div.
`default_nettype none

// Height-based blending of four terrain layers. One pixel transaction is
// accepted per clock while the output side does not stall, and one result
// transaction leaves per pixel, in order. The depth is set by three divider
// pipelines (splat renormalization, ramp, final normalization), each
// resolving two quotient bits per stage over eight stages, plus seven stages
// for clamping, the boost multiply, the height maximum, the ramp numerator,
// the sums and the output register. The whole pipeline advances together
// whenever the output register is empty or being taken. Registers: index 0
// is sharpness, index 1 is transition width; other indexes are ignored.
// Write them only while the pipeline is empty.

module height_blend_layer_weights
    import hblw_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  pixel_valid,
    output logic                       pixel_ready,
    input  wire pixel_t                pixel,
    output logic                       blend_valid,
    input  wire logic                  blend_ready,
    output blend_t                     blend,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int L = LAYER_COUNT;

    logic [CFG_DATA_W-1:0] sharpness_reg;
    logic [CFG_DATA_W-1:0] transition_reg;
    logic                  adv;

    assign cfg_ready   = 1'b1;
    assign adv         = !blend_valid || blend_ready;
    assign pixel_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sharpness_reg  <= SHARPNESS_RESET;
            transition_reg <= TRANSITION_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_SHARPNESS)
            begin
                sharpness_reg <= cfg_data;
            end
            else if (cfg_index == REG_TRANSITION)
            begin
                transition_reg <= cfg_data;
            end
        end
    end

    // Stage 0: clamp splats and sum them.
    logic signed [15:0]      ht_in [L];
    logic signed [15:0]      sp_in [L];
    logic [L-1:0][14:0]      s_next;
    logic [SUM_W-1:0]        ssum_next;

    always_comb
    begin
        ht_in[0] = pixel.height_0;
        ht_in[1] = pixel.height_1;
        ht_in[2] = pixel.height_2;
        ht_in[3] = pixel.height_3;
        sp_in[0] = pixel.splat_0;
        sp_in[1] = pixel.splat_1;
        sp_in[2] = pixel.splat_2;
        sp_in[3] = pixel.splat_3;
        ssum_next = '0;
        for (int i = 0; i < L; i++)
        begin
            s_next[i] = sp_in[i][15] ? 15'd0 : sp_in[i][14:0];
            ssum_next = ssum_next + SUM_W'(s_next[i]);
        end
    end

    logic                    v0_reg;
    logic [L-1:0][14:0]      s0_reg;
    logic [L-1:0][15:0]      ht0_reg;
    logic [SUM_W-1:0]        ssum0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else if (adv)
        begin
            v0_reg <= pixel_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_reg    <= s_next;
            ssum0_reg <= ssum_next;
            for (int i = 0; i < L; i++)
            begin
                ht0_reg[i] <= ht_in[i];
            end
        end
    end

    // Splat renormalization. An all-zero splat divides zeros by one.
    logic [L-1:0][SUM_W-1:0] d1_num;
    logic [SUM_W-1:0]        d1_den;
    logic                    d1_valid;
    logic [L-1:0][Q_W-1:0]   d1_quo;
    logic [L*16-1:0]         d1_side;

    always_comb
    begin
        for (int i = 0; i < L; i++)
        begin
            d1_num[i] = SUM_W'(s0_reg[i]);
        end
        d1_den = (ssum0_reg == '0) ? SUM_W'(1) : ssum0_reg;
    end

    hblw_div #(
        .DW    (SUM_W),
        .LANES (L),
        .SIDE  (L * 16)
    ) u_div_splat (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (v0_reg),
        .num       (d1_num),
        .den       (d1_den),
        .side_in   (ht0_reg),
        .out_valid (d1_valid),
        .quo       (d1_quo),
        .side_out  (d1_side)
    );

    // Stage 1: boost product. Stage 2: adjusted height. Stage 3: maximum.
    logic                       v1_reg, v2_reg, v3_reg, v4_reg;
    logic [L-1:0][Q_W-1:0]      w1_reg, w2_reg, w3_reg, w4_reg;
    logic [L-1:0][30:0]         prod1_reg;
    logic [L-1:0][15:0]         ht1_reg;
    logic signed [H_W-1:0]      h2_reg [L];
    logic signed [H_W-1:0]      h3_reg [L];
    logic signed [H_W-1:0]      hmax3_reg;
    logic [L-1:0][14:0]         n4_reg;
    logic signed [H_W-1:0]      hmax_next;
    logic [14:0]                te;
    logic [L-1:0][14:0]         n_next;

    always_comb
    begin
        hmax_next = h2_reg[0];
        for (int i = 1; i < L; i++)
        begin
            if (h2_reg[i] > hmax_next)
            begin
                hmax_next = h2_reg[i];
            end
        end
    end

    assign te = (transition_reg < MIN_TRANSITION) ? MIN_TRANSITION : transition_reg;

    // The numerator never exceeds te, since no layer lies above the maximum.
    always_comb
    begin
        logic signed [N_W-1:0] num;
        for (int i = 0; i < L; i++)
        begin
            num = N_W'(h3_reg[i]) - N_W'(hmax3_reg) + $signed({{(N_W-15){1'b0}}, te});
            n_next[i] = (num <= 0) ? 15'd0 : num[14:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= d1_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            w1_reg    <= d1_quo;
            ht1_reg   <= d1_side;
            w2_reg    <= w1_reg;
            w3_reg    <= w2_reg;
            w4_reg    <= w3_reg;
            hmax3_reg <= hmax_next;
            n4_reg    <= n_next;
            for (int i = 0; i < L; i++)
            begin
                prod1_reg[i] <= 31'(sharpness_reg) * 31'(d1_quo[i]);
                h2_reg[i]    <= H_W'($signed(ht1_reg[i]))
                                + $signed({2'b00, prod1_reg[i][30:15]});
                h3_reg[i]    <= h2_reg[i];
            end
        end
    end

    // Ramp division by the band width.
    logic                    d2_valid;
    logic [L-1:0][Q_W-1:0]   d2_quo;
    logic [L*16-1:0]         d2_side;

    hblw_div #(
        .DW    (15),
        .LANES (L),
        .SIDE  (L * 16)
    ) u_div_ramp (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (v4_reg),
        .num       (n4_reg),
        .den       (te),
        .side_in   (w4_reg),
        .out_valid (d2_valid),
        .quo       (d2_quo),
        .side_out  (d2_side)
    );

    // Stage 5: ramp sum.
    logic                    v5_reg;
    logic [L-1:0][Q_W-1:0]   r5_reg;
    logic [L*16-1:0]         w5_reg;
    logic [SUM_W-1:0]        rsum5_reg;
    logic [SUM_W-1:0]        rsum_next;

    always_comb
    begin
        rsum_next = '0;
        for (int i = 0; i < L; i++)
        begin
            rsum_next = rsum_next + SUM_W'(d2_quo[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
        end
        else if (adv)
        begin
            v5_reg <= d2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r5_reg    <= d2_quo;
            w5_reg    <= d2_side;
            rsum5_reg <= rsum_next;
        end
    end

    // Final normalization; an all-zero ramp set falls back to the splat.
    logic [L-1:0][SUM_W-1:0] d3_num;
    logic [SUM_W-1:0]        d3_den;
    logic                    d3_valid;
    logic [L-1:0][Q_W-1:0]   d3_quo;
    logic [L*16:0]           d3_side;

    always_comb
    begin
        for (int i = 0; i < L; i++)
        begin
            d3_num[i] = SUM_W'(r5_reg[i]);
        end
        d3_den = (rsum5_reg == '0) ? SUM_W'(1) : rsum5_reg;
    end

    hblw_div #(
        .DW    (SUM_W),
        .LANES (L),
        .SIDE  (L * 16 + 1)
    ) u_div_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (v5_reg),
        .num       (d3_num),
        .den       (d3_den),
        .side_in   ({w5_reg, rsum5_reg == '0}),
        .out_valid (d3_valid),
        .quo       (d3_quo),
        .side_out  (d3_side)
    );

    // Output register.
    logic                  fallback;
    logic [L-1:0][15:0]    w_fb;
    logic [L-1:0][15:0]    w_sel;
    blend_t                blend_next;

    always_comb
    begin
        fallback = (sharpness_reg == '0) || d3_side[0];
        w_fb     = d3_side[L*16:1];
        w_sel    = fallback ? w_fb : d3_quo;
        blend_next.weight_0   = w_sel[0];
        blend_next.weight_1   = w_sel[1];
        blend_next.weight_2   = w_sel[2];
        blend_next.weight_3   = w_sel[3];
        blend_next.used_splat = fallback;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blend_valid <= 1'b0;
        end
        else if (adv)
        begin
            blend_valid <= d3_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            blend <= blend_next;
        end
    end

    a_splat_when_no_sharpness: assert property (@(posedge clk) disable iff (!rst_n)
        blend_valid && sharpness_reg == '0 |-> blend.used_splat)
        else $error("zero sharpness did not select the splat");

    a_blend_sum: assert property (@(posedge clk) disable iff (!rst_n)
        blend_valid && !blend.used_splat |->
            ({2'b00, blend.weight_0} + {2'b00, blend.weight_1}
             + {2'b00, blend.weight_2} + {2'b00, blend.weight_3}) <= {1'b0, ONE_Q15})
        else $error("blend weights sum above one");

    a_weight_range: assert property (@(posedge clk) disable iff (!rst_n)
        blend_valid |-> {1'b0, blend.weight_0} <= ONE_Q15 && {1'b0, blend.weight_1} <= ONE_Q15
            && {1'b0, blend.weight_2} <= ONE_Q15 && {1'b0, blend.weight_3} <= ONE_Q15)
        else $error("layer weight above one");

endmodule

`default_nettype wire

### sim/tb_top.sv
// Self-checking bench for height_blend_layer_weights: random and directed pixels
// against a built-in prediction of the layer weights. Depends on hblw_pkg.
`default_nettype none

module tb_top;
    import hblw_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic pixel_valid = 1'b0;
    logic pixel_ready;
    pixel_t pixel = '0;
    logic blend_valid;
    logic blend_ready = 1'b0;
    blend_t blend;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    height_blend_layer_weights u_top (
        .clk(clk), .rst_n(rst_n),
        .pixel_valid(pixel_valid), .pixel_ready(pixel_ready), .pixel(pixel),
        .blend_valid(blend_valid), .blend_ready(blend_ready), .blend(blend),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    pixel_t pending_pixels[$];
    blend_t expected_blends[$];
    int unsigned send_idle_pct = 0;
    int unsigned take_stall_pct = 0;
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    logic [14:0] gain_k = SHARPNESS_RESET;
    logic [14:0] band_t = TRANSITION_RESET;

    function automatic blend_t blend_weights(pixel_t p, logic [14:0] k, logic [14:0] t);
        longint w[4];
        longint r[4];
        longint h[4];
        longint hs[4];
        longint ss[4];
        longint ssum;
        longint rsum;
        longint hmax;
        longint te;
        longint num;
        longint q;
        blend_t res;
        hs = '{p.height_0, p.height_1, p.height_2, p.height_3};
        ss = '{p.splat_0, p.splat_1, p.splat_2, p.splat_3};
        ssum = 0;
        rsum = 0;
        hmax = 0;
        res.used_splat = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            w[i] = ss[i] > 0 ? ss[i] : 0;
            ssum += w[i];
        end
        if (ssum > 0)
            for (int i = 0; i < 4; i++)
                w[i] = (w[i] << 15) / ssum;
        if (k == 0)
            res.used_splat = 1'b1;
        else
        begin
            te = t < 4 ? 4 : t;
            for (int i = 0; i < 4; i++)
            begin
                h[i] = hs[i] + ((longint'(k) * w[i]) >>> 15);
                if (i == 0 || h[i] > hmax)
                    hmax = h[i];
            end
            for (int i = 0; i < 4; i++)
            begin
                num = h[i] - hmax + te;
                if (num <= 0)
                    r[i] = 0;
                else
                begin
                    q = (num << 15) / te;
                    r[i] = q > 32768 ? 32768 : q;
                end
                rsum += r[i];
            end
            if (rsum == 0)
                res.used_splat = 1'b1;
            else
                for (int i = 0; i < 4; i++)
                    w[i] = (r[i] << 15) / rsum;
        end
        res.weight_0 = w[0][15:0];
        res.weight_1 = w[1][15:0];
        res.weight_2 = w[2][15:0];
        res.weight_3 = w[3][15:0];
        return res;
    endfunction

    // Driver: the expectation is computed when the pixel transaction is accepted.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (pixel_valid && pixel_ready)
        begin
            expected_blends.push_back(blend_weights(pixel, gain_k, band_t));
        end
        if (!rst_n)
            pixel_valid <= 1'b0;
        else if (!pixel_valid || pixel_ready)
        begin
            if (pending_pixels.size() > 0 && $urandom_range(99, 0) >= send_idle_pct)
            begin
                pixel <= pending_pixels.pop_front();
                pixel_valid <= 1'b1;
            end
            else
                pixel_valid <= 1'b0;
        end
        blend_ready <= rst_n && $urandom_range(99, 0) >= take_stall_pct;
    end

    // Monitor.
    always @(posedge clk)
    begin
        blend_t exp_b;
        if (blend_valid && blend_ready)
        begin
            if (expected_blends.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, blend);
                error_count++;
            end
            else
            begin
                exp_b = expected_blends.pop_front();
                if (exp_b.weight_0 !== blend.weight_0 || exp_b.weight_1 !== blend.weight_1
                    || exp_b.weight_2 !== blend.weight_2 || exp_b.weight_3 !== blend.weight_3
                    || exp_b.used_splat !== blend.used_splat)
                begin
                    $display("%0t: mismatch expected %h actual %h", $time, exp_b, blend);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (cycle_count > 400000)
        begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == REG_SHARPNESS)
            gain_k = val;
        else if (idx == REG_TRANSITION)
            band_t = val;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // The queues and the valid flag are checked on the falling edge, once every
    // update of the rising edge has settled.
    task automatic drain();
        while (pending_pixels.size() > 0 || pixel_valid || expected_blends.size() > 0)
            @(negedge clk);
        repeat (40) @(posedge clk);
    endtask

    function automatic logic [15:0] rand_field(int mode);
        case ($urandom_range(7, 0))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return mode ? 16'(($urandom_range(40, 0))) : 16'($urandom_range(1023, 0) - 512);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic queue_random(int count);
        pixel_t p;
        for (int n = 0; n < count; n++)
        begin
            p.height_0 = rand_field(0);
            p.height_1 = $urandom_range(3, 0) == 0 ? p.height_0 : rand_field(0);
            p.height_2 = rand_field(0);
            p.height_3 = rand_field(0);
            p.splat_0 = rand_field(1);
            p.splat_1 = rand_field(1);
            p.splat_2 = rand_field(1);
            p.splat_3 = rand_field(1);
            pending_pixels.push_back(p);
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, all splat nonpositive, equal heights, passthrough.
        pending_pixels.push_back('0);
        pending_pixels.push_back({8{16'h7fff}});
        pending_pixels.push_back({8{16'h8000}});
        pending_pixels.push_back({16'h7fff, 16'h8000, 16'h0, 16'h1000,
                                  16'h8000, 16'hffff, 16'h0, 16'h0});
        pending_pixels.push_back({16'h100, 16'h100, 16'h100, 16'h100,
                                  16'h7fff, 16'h0, 16'h0, 16'h0});
        pending_pixels.push_back({16'h8000, 16'h7fff, 16'h8000, 16'h8000,
                                  16'h7fff, 16'h0001, 16'h7fff, 16'h4000});
        drain();
        write_reg(REG_SHARPNESS, 15'd0);
        write_reg(REG_TRANSITION, 15'd0);
        pending_pixels.push_back({16'h0, 16'h10, 16'h20, 16'h30,
                                  16'h1, 16'h2, 16'h3, 16'h8000});
        queue_random(10);
        drain();
        write_reg(REG_SHARPNESS, 15'h7fff);
        write_reg(REG_TRANSITION, 15'h7fff);
        queue_random(10);
        drain();
        write_reg(2'd2, 15'h1234);
        write_reg(2'd3, 15'h0);
        write_reg(REG_TRANSITION, 15'd3);
        queue_random(10);
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(REG_SHARPNESS, ph == 5 ? 15'd1 : 15'($urandom));
            write_reg(REG_TRANSITION, ph == 4 ? 15'd4 : 15'($urandom_range(8191, 0)));
            send_idle_pct = ph < 2 ? 14 : (ph < 4 ? 88 : 0);
            take_stall_pct = ph < 2 ? 88 : (ph < 4 ? 14 : 0);
            queue_random(250);
            drain();
        end

        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

`default_nettype wire
